// ----- rtl/ncdf_pkg.sv -----
// Package for the normal cumulative distribution core.
// Holds the fixed-point widths, the sequencer types and the polynomial coefficient tables.
// Depends on nothing.
package ncdf_pkg;

  // Input z score format and fixed output format.
  localparam int FRAC_BITS = 16;
  localparam int IN_W      = 20;
  localparam int OUT_FRAC  = 16;
  localparam int OUT_W     = 17;

  // Internal Q3.30 arithmetic.
  localparam int Q       = 30;
  localparam int ACC_W   = 34;
  localparam int OPB_W   = 32;
  localparam int PROD_W  = ACC_W + OPB_W;
  localparam int RND_W   = 37;
  localparam int SUM_W   = 38;
  localparam int Y_W     = 33;
  localparam int IDX_W   = 4;

  localparam logic signed [ACC_W-1:0] ONE_Q   = ACC_W'(64'sd1 <<< Q);
  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'((64'sd1 <<< 33) - 64'sd1);
  localparam logic [31:0] TAIL_LIM = 32'(64'd6 << FRAC_BITS);
  localparam int          Y_SHIFT  = Q - 1 - FRAC_BITS;

  // Last coefficient index of each polynomial.
  localparam logic [IDX_W-1:0] LO_LAST = IDX_W'(8);
  localparam logic [IDX_W-1:0] HI_LAST = IDX_W'(14);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_FOLD
  } state_t;

  typedef enum logic [1:0] {
    OP_SQUARE,
    OP_HORNER,
    OP_FINAL
  } op_t;

  // Coefficients in Q3.30, the low range polynomial in y squared and the
  // high range polynomial in y minus 2, highest power first.
  function automatic logic signed [ACC_W-1:0] coef(input logic hi_sel,
                                                   input logic [IDX_W-1:0] idx);
    logic signed [ACC_W-1:0] c;
    c = '0;
    if (!hi_sel) begin
      case (idx)
        4'd0:    c = 34'sd134023;
        4'd1:    c = -34'sd1154492;
        4'd2:    c = 34'sd5582142;
        4'd3:    c = -34'sd20614009;
        4'd4:    c = 34'sd63408788;
        4'd5:    c = -34'sd163175204;
        4'd6:    c = 34'sd342687852;
        4'd7:    c = -34'sd571147980;
        4'd8:    c = 34'sd856722023;
        default: c = '0;
      endcase
    end else begin
      case (idx)
        4'd0:    c = -34'sd48593;
        4'd1:    c = 34'sd163777;
        4'd2:    c = -34'sd20979;
        4'd3:    c = -34'sd726821;
        4'd4:    c = 34'sd1493150;
        4'd5:    c = -34'sd853218;
        4'd6:    c = -34'sd2184265;
        4'd7:    c = 34'sd7032785;
        4'd8:    c = -34'sd11336164;
        4'd9:    c = 34'sd12488098;
        4'd10:   c = -34'sd9963737;
        4'd11:   c = 34'sd5748362;
        4'd12:   c = -34'sd2299170;
        4'd13:   c = 34'sd574786;
        4'd14:   c = 34'sd1073673811;
        default: c = '0;
      endcase
    end
    return c;
  endfunction

endpackage

// ----- rtl/normal_cdf_polynomial_core.sv -----
// Top level of the normal cumulative distribution core.
// One shared multiply unit and a rounding adder run every Horner step.
// Depends on ncdf_pkg.

// A z score word is taken when start is high and busy is low; busy then stays high
// until the probability word appears on probability with done high for exactly one
// cycle, and the receiver must take it in that cycle. Every Horner step goes
// through the one shared 34 by 32 bit multiplier (multiply, then round, add the
// coefficient and saturate). For |z| below 2 the core runs a squaring step, eight
// steps and a final product, for |z| from 2 up to 6 fourteen steps, and in the
// saturated tail it goes straight to the fold. A new word can be started in the
// cycle in which done is high.
module normal_cdf_polynomial_core
  import ncdf_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [IN_W-1:0]  z_score,
  output logic                    done,
  output logic [OUT_W-1:0]        probability
);

  state_t state, state_next;

  op_t                      op, op_next;
  logic                     hi_sel, hi_sel_next;
  logic                     pos, pos_next;
  logic [IDX_W-1:0]         idx, idx_next;
  logic signed [ACC_W-1:0]  acc, acc_next;
  logic signed [OPB_W-1:0]  t, t_next;
  logic signed [OPB_W-1:0]  y, y_next;
  logic signed [PROD_W-1:0] prod;
  logic [OUT_W-1:0]         probability_next;
  logic                     done_next;

  // Input decode: magnitude, range selection and the Q2.30 half magnitude.
  logic                     accept;
  logic                     neg_in;
  logic [IN_W-1:0]          mag;
  logic signed [Y_W-1:0]    y_full;
  logic signed [Y_W-1:0]    t_hi;
  logic                     tail;
  logic                     lo_range;

  assign accept   = start && !busy;
  assign neg_in   = z_score[IN_W-1];
  assign mag      = neg_in ? (~z_score + IN_W'(1)) : z_score;
  assign y_full   = Y_W'({{(Y_W-IN_W){1'b0}}, mag} << Y_SHIFT);
  assign t_hi     = y_full - Y_W'(2 * ONE_Q);
  assign tail     = 32'(mag) >= TAIL_LIM;
  assign lo_range = y_full < Y_W'(ONE_Q);

  // Shared multiplier operands.
  logic signed [ACC_W-1:0]  mul_a;
  logic signed [OPB_W-1:0]  mul_b;

  assign mul_a = (op == OP_SQUARE) ? ACC_W'(y) : acc;
  assign mul_b = (op == OP_HORNER) ? t : y;

  // Round to nearest, add the coefficient, double or pass the square, then saturate.
  logic signed [PROD_W-1:0] prod_r;
  logic signed [RND_W-1:0]  rnd;
  logic signed [SUM_W-1:0]  step_sum;
  logic signed [ACC_W-1:0]  step_sat;
  logic signed [ACC_W-1:0]  step_coef;

  assign prod_r    = prod + PROD_W'(64'sd1 <<< (Q - 1));
  assign rnd       = RND_W'(prod_r >>> Q);
  assign step_coef = coef(hi_sel, idx);

  always_comb begin
    case (op)
      OP_SQUARE: step_sum = SUM_W'(rnd);
      OP_FINAL:  step_sum = SUM_W'(rnd) <<< 1;
      default:   step_sum = SUM_W'(rnd) + SUM_W'(step_coef);
    endcase
    if (step_sum > SUM_W'(ACC_MAX)) begin
      step_sat = ACC_MAX;
    end else if (step_sum < -SUM_W'(ACC_MAX)) begin
      step_sat = -ACC_MAX;
    end else begin
      step_sat = ACC_W'(step_sum);
    end
  end

  // Fold by the sign of z and round to Q1.16.
  logic signed [ACC_W-1:0]  x_clamp;
  logic [ACC_W-1:0]         fold_sum;
  logic [ACC_W-1:0]         fold_rnd;

  always_comb begin
    if (acc < 0) begin
      x_clamp = '0;
    end else if (acc > ONE_Q) begin
      x_clamp = ONE_Q;
    end else begin
      x_clamp = acc;
    end
    fold_sum = pos ? ACC_W'(ONE_Q + x_clamp) : ACC_W'(ONE_Q - x_clamp);
    fold_rnd = (fold_sum + ACC_W'(64'd1 << (Q - OUT_FRAC))) >> (Q + 1 - OUT_FRAC);
  end

  // Next state of the sequencer.
  logic last_step;
  assign last_step = idx == (hi_sel ? HI_LAST : LO_LAST);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = tail ? ST_FOLD : ST_MUL;
        end
      end
      ST_MUL: state_next = ST_ADD;
      ST_ADD: begin
        if (op == OP_HORNER && last_step && hi_sel) begin
          state_next = ST_FOLD;
        end else if (op == OP_FINAL) begin
          state_next = ST_FOLD;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_FOLD: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath loads and outputs of the sequencer.
  always_comb begin
    op_next          = op;
    hi_sel_next      = hi_sel;
    pos_next         = pos;
    idx_next         = idx;
    acc_next         = acc;
    t_next           = t;
    y_next           = y;
    probability_next = probability;
    done_next        = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          pos_next    = !neg_in && (mag != '0);
          hi_sel_next = !lo_range;
          y_next      = OPB_W'(y_full);
          t_next      = OPB_W'(t_hi);
          idx_next    = IDX_W'(1);
          if (tail) begin
            acc_next = ONE_Q;
          end else if (lo_range) begin
            op_next = OP_SQUARE;
          end else begin
            op_next  = OP_HORNER;
            acc_next = coef(1'b1, '0);
          end
        end
      end
      ST_ADD: begin
        case (op)
          OP_SQUARE: begin
            t_next   = OPB_W'(step_sat);
            acc_next = coef(1'b0, '0);
            idx_next = IDX_W'(1);
            op_next  = OP_HORNER;
          end
          OP_HORNER: begin
            acc_next = step_sat;
            idx_next = idx + IDX_W'(1);
            if (last_step && !hi_sel) begin
              op_next = OP_FINAL;
            end
          end
          OP_FINAL: acc_next = step_sat;
          default:  acc_next = acc;
        endcase
      end
      ST_FOLD: begin
        probability_next = OUT_W'(fold_rnd);
        done_next        = 1'b1;
      end
      default: done_next = 1'b0;
    endcase
  end

  assign busy = state != ST_IDLE;

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  // Payload registers and the shared multiplier.
  always_ff @(posedge clk) begin
    op          <= op_next;
    hi_sel      <= hi_sel_next;
    pos         <= pos_next;
    idx         <= idx_next;
    acc         <= acc_next;
    t           <= t_next;
    y           <= y_next;
    probability <= probability_next;
    if (state == ST_MUL) begin
      prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
  end

`ifndef NO_ASSERTIONS
  // A result word only follows the fold cycle.
  a_done_after_fold: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == ST_FOLD)
    else $error("done without a preceding fold cycle");

  // The probability never exceeds one.
  a_prob_range: assert property (@(posedge clk) disable iff (rst)
    done |-> probability <= OUT_W'(1 << OUT_FRAC))
    else $error("probability above one");

  // An accepted word keeps the core busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("core not busy after accepting a word");

  // The coefficient index stays within the selected polynomial while stepping.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADD && op == OP_HORNER) |-> idx <= (hi_sel ? HI_LAST : LO_LAST))
    else $error("coefficient index out of range");
`endif

endmodule
